/* src/wts_pkg.sv */
`default_nettype none
package wts_pkg;

   localparam int CountBits    = 12;
   localparam int CentiBits    = 14;
   localparam int QuotBits     = 14;
   localparam int IntervalBits = 4;

   localparam logic [CountBits-1:0] WindowReset = 12'd1199;

   // round(x * 10000 / den) is done as (2 * 10000 * x + den) / (2 * den)
   localparam int CentiSpanTwice = 20000;
   localparam logic [CentiBits-1:0] CentiOffset = 14'd5000;

endpackage
`default_nettype wire

/* src/wts_accum.sv */
`default_nettype none
module wts_accum #(
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 accept,
   input  wire logic [SAMPLE_BITS-1:0]               sample,
   input  wire logic [wts_pkg::CountBits-1:0]        window_length,
   output logic                                      close_now,
   output logic [SAMPLE_BITS-1:0]                    snap_min,
   output logic [SAMPLE_BITS-1:0]                    snap_max,
   output logic [SAMPLE_BITS+wts_pkg::CountBits-1:0] snap_sum,
   output logic [wts_pkg::CountBits:0]               snap_count
);

   localparam int SumBits = SAMPLE_BITS + wts_pkg::CountBits;
   localparam int CntBits = wts_pkg::CountBits;

   logic [CntBits-1:0]     count_ff, count_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SumBits-1:0]     sum_ff, sum_in;
   logic [CntBits-1:0]     limit;

   logic [SAMPLE_BITS-1:0] snap_min_ff;
   logic [SAMPLE_BITS-1:0] snap_max_ff;
   logic [SumBits-1:0]     snap_sum_ff;
   logic [CntBits:0]       snap_count_ff;

   always_comb begin
      count_in = count_ff + CntBits'(1);
      min_in   = (sample < min_ff) ? sample : min_ff;
      max_in   = (sample > max_ff) ? sample : max_ff;
      sum_in   = sum_ff + SumBits'(sample);
      limit    = (window_length == '0) ? CntBits'(1) : window_length;
      // a wrapped count also closes the window
      close_now = (count_in >= limit) || (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         sum_ff   <= '0;
      end else if (accept) begin
         if (close_now) begin
            count_ff <= '0;
            min_ff   <= '1;
            max_ff   <= '0;
            sum_ff   <= '0;
         end else begin
            count_ff <= count_in;
            min_ff   <= min_in;
            max_ff   <= max_in;
            sum_ff   <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && close_now) begin
         snap_min_ff   <= min_in;
         snap_max_ff   <= max_in;
         snap_sum_ff   <= sum_in;
         snap_count_ff <= (count_in == '0) ? {1'b1, CntBits'(0)} : {1'b0, count_in};
      end
   end

   assign snap_min   = snap_min_ff;
   assign snap_max   = snap_max_ff;
   assign snap_sum   = snap_sum_ff;
   assign snap_count = snap_count_ff;

endmodule
`default_nettype wire

/* src/wts_div.sv */
`default_nettype none
module wts_div #(
   parameter int NUM_BITS = 25
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [NUM_BITS-1:0]          num,
   input  wire logic [NUM_BITS-1:0]          den,
   output logic                              done,
   output logic [wts_pkg::QuotBits-1:0]      quot
);

   localparam int QBits   = wts_pkg::QuotBits;
   localparam int RemBits = NUM_BITS + 16;
   localparam int CBits   = $clog2(QBits);

   logic [RemBits-1:0] rem_ff, rem_in;
   logic [RemBits-1:0] dsr_ff, dsr_in;
   logic [QBits-1:0]   quot_ff, quot_in;
   logic [CBits-1:0]   step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               fits;

   // restoring division, one quotient bit per cycle, msb first
   always_comb begin
      fits    = rem_ff >= dsr_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = RemBits'(num) * RemBits'(wts_pkg::CentiSpanTwice) + RemBits'(den);
         dsr_in  = RemBits'(den) << QBits;
         quot_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_ff - dsr_ff : rem_ff;
         dsr_in  = dsr_ff >> 1;
         quot_in = {quot_ff[QBits-2:0], fits};
         step_in = step_ff + CBits'(1);
         if (step_ff == CBits'(QBits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

/* src/windowed_temperature_statistics.sv */
// a sample that does not close the window is accepted at once: one transfer per clock while idle
// a closing sample holds off input until its result is computed and loaded:
// three conversions, min, max and average, run in turn on the shared shift-subtract divider,
// then the output register is loaded; a finished result waits there without blocking input
// synchronous active-high reset: empty window, interval 0, window length 1199
`default_nettype none
module windowed_temperature_statistics #(
   parameter int SAMPLE_BITS    = 12,
   parameter int INTERVAL_COUNT = 10
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [SAMPLE_BITS-1:0]                req_sample_raw,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [wts_pkg::CentiBits-1:0]       rsp_min_centi,
   output logic signed [wts_pkg::CentiBits-1:0]       rsp_max_centi,
   output logic signed [wts_pkg::CentiBits-1:0]       rsp_avg_centi,
   output logic [wts_pkg::IntervalBits-1:0]           rsp_interval_number,
   input  wire logic                                  csr_wr_en,
   input  wire logic [wts_pkg::CountBits-1:0]         csr_wr_data
);

   localparam int SumBits  = SAMPLE_BITS + wts_pkg::CountBits;
   localparam int NumBits  = SAMPLE_BITS + wts_pkg::CountBits + 1;
   localparam int CBits    = wts_pkg::CentiBits;
   localparam int IBits    = wts_pkg::IntervalBits;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MIN,
      S_MAX,
      S_AVG,
      S_HOLD
   } state_type;

   state_type                     state_ff;
   logic                          start_ff;
   logic                          start_in;
   logic                          load_rsp;
   logic [wts_pkg::CountBits-1:0] window_length_ff;
   logic [IBits-1:0]              interval_ff;
   logic [IBits-1:0]              snap_interval_ff;
   logic [CBits-1:0]              res_min_ff;
   logic [CBits-1:0]              res_max_ff;
   logic [CBits-1:0]              res_avg_ff;
   logic                          rsp_valid_ff;
   logic [CBits-1:0]              rsp_min_ff;
   logic [CBits-1:0]              rsp_max_ff;
   logic [CBits-1:0]              rsp_avg_ff;
   logic [IBits-1:0]              rsp_interval_ff;

   logic                          accept;
   logic                          close_now;
   logic [SAMPLE_BITS-1:0]        snap_min;
   logic [SAMPLE_BITS-1:0]        snap_max;
   logic [SumBits-1:0]            snap_sum;
   logic [wts_pkg::CountBits:0]   snap_count;

   logic [NumBits-1:0]            div_num;
   logic [NumBits-1:0]            div_den;
   logic                          div_done;
   logic [wts_pkg::QuotBits-1:0]  div_quot;
   logic [CBits-1:0]              centi;
   logic [NumBits-1:0]            full_scale;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // kick the divider on a closing sample and after each of the first two conversions
   assign start_in = (accept && close_now) ||
                     (((state_ff == S_MIN) || (state_ff == S_MAX)) && div_done);
   // load once the previous result has been taken
   assign load_rsp = (state_ff == S_HOLD) && (!rsp_valid_ff || rsp_ready);

   wts_accum #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .sample       (req_sample_raw),
      .window_length(window_length_ff),
      .close_now    (close_now),
      .snap_min     (snap_min),
      .snap_max     (snap_max),
      .snap_sum     (snap_sum),
      .snap_count   (snap_count)
   );

   // full scale is 2^bits - 1, so n * full scale is a shift and a subtract
   always_comb begin
      full_scale = (NumBits'(1) << SAMPLE_BITS) - NumBits'(1);
      case (state_ff)
         S_MIN: begin
            div_num = NumBits'(snap_min);
            div_den = full_scale;
         end
         S_MAX: begin
            div_num = NumBits'(snap_max);
            div_den = full_scale;
         end
         S_AVG: begin
            div_num = NumBits'(snap_sum);
            div_den = (NumBits'(snap_count) << SAMPLE_BITS) - NumBits'(snap_count);
         end
         default: begin
            div_num = '0;
            div_den = full_scale;
         end
      endcase
   end

   wts_div #(
      .NUM_BITS(NumBits)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(start_ff),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quot (div_quot)
   );

   assign centi = CBits'(div_quot) - wts_pkg::CentiOffset;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         start_ff         <= 1'b0;
         window_length_ff <= wts_pkg::WindowReset;
         interval_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         start_ff <= start_in;
         if (csr_wr_en) begin
            window_length_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept && close_now) begin
                  snap_interval_ff <= interval_ff;
                  interval_ff <= (interval_ff == IBits'(INTERVAL_COUNT - 1)) ?
                                 '0 : interval_ff + IBits'(1);
                  state_ff <= S_MIN;
               end
            end
            S_MIN: begin
               if (div_done) begin
                  res_min_ff <= centi;
                  state_ff   <= S_MAX;
               end
            end
            S_MAX: begin
               if (div_done) begin
                  res_max_ff <= centi;
                  state_ff   <= S_AVG;
               end
            end
            S_AVG: begin
               if (div_done) begin
                  res_avg_ff <= centi;
                  state_ff   <= S_HOLD;
               end
            end
            S_HOLD: begin
               if (load_rsp) begin
                  rsp_min_ff      <= res_min_ff;
                  rsp_max_ff      <= res_max_ff;
                  rsp_avg_ff      <= res_avg_ff;
                  rsp_interval_ff <= snap_interval_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_min_centi       = rsp_min_ff;
   assign rsp_max_centi       = rsp_max_ff;
   assign rsp_avg_centi       = rsp_avg_ff;
   assign rsp_interval_number = rsp_interval_ff;

endmodule
`default_nettype wire
